>>> rtl/hrhc_pkg.sv
// Shared types and constants for the HTTP request header checker.
`default_nettype none
package hrhc_pkg;

	typedef enum logic [3:0] {
		PH_METHOD = 4'd0,
		PH_GAP1   = 4'd1,
		PH_URL    = 4'd2,
		PH_GAP2   = 4'd3,
		PH_VER    = 4'd4,
		PH_HMATCH = 4'd5,
		PH_HSKIP  = 4'd6,
		PH_HVALUE = 4'd7,
		PH_HOTHER = 4'd8,
		PH_DONE   = 4'd9,
		PH_BAD    = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		UF_NONE  = 2'd0,
		UF_PROTO = 2'd1,
		UF_HOST  = 2'd2,
		UF_PATH  = 2'd3
	} url_form_t;

	localparam logic [1:0] VERDICT_PENDING = 2'd0;
	localparam logic [1:0] VERDICT_GET     = 2'd1;
	localparam logic [1:0] VERDICT_BAD     = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam int LEN_GET   = 3;
	localparam int LEN_VER   = 8;
	localparam int LEN_PROTO = 7;
	localparam int LEN_HOST  = 5;

	localparam logic [7:0] LIT_GET [LEN_GET] = '{8'h67, 8'h65, 8'h74};
	localparam logic [7:0] LIT_VER [LEN_VER] =
		'{8'h68, 8'h74, 8'h74, 8'h70, 8'h2f, 8'h31, 8'h2e, 8'h31};
	localparam logic [7:0] LIT_PROTO [LEN_PROTO] =
		'{8'h68, 8'h74, 8'h74, 8'h70, 8'h3a, 8'h2f, 8'h2f};
	localparam logic [7:0] LIT_HOST [LEN_HOST] = '{8'h68, 8'h6f, 8'h73, 8'h74, 8'h3a};

	typedef struct packed {
		logic                 is_blank;
		logic                 is_cr;
		logic                 is_lf;
		logic                 is_slash;
		logic [LEN_GET-1:0]   get_hit;
		logic [LEN_VER-1:0]   ver_hit;
		logic [LEN_PROTO-1:0] proto_hit;
		logic [LEN_HOST-1:0]  host_hit;
	} byte_class_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       url_byte;
		logic       host_byte;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/http_request_header_checker.sv
// HTTP request header checker top level.
//
// Request bytes enter through a queue-style port: a transaction takes place at a
// clock edge where push is high and full is low, one byte per transaction.
// Each byte yields exactly one result (verdict, url_byte, host_byte), offered on
// a queue-style output: the oldest result is valid while empty is low and is
// taken at an edge where pop is high.
// The front end classifies a byte and queues it (QUEUE_DEPTH entries); the back
// end runs the grammar state machine on one queued byte per cycle while the
// result queue is not full, writing the result into it (QUEUE_DEPTH entries).
// The byte waits in the class queue until the back end takes it; its result is
// then written to the result queue, where empty goes low and it can be popped.
// Throughput is one byte per cycle while the result queue is not full.
// When pop is held low the result queue fills, the back end stops, the byte
// queue fills and full rises; nothing is lost.
// Asynchronous reset empties both queues and puts the checker at the start of
// the request line. After a GET or bad verdict, every later byte repeats it
// until the next reset.
`default_nettype none
module http_request_header_checker #(
	parameter int MAX_LINE    = 4096,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] byte_req,
	input  wire logic       pop,
	output logic            empty,
	output logic [1:0]      verdict,
	output logic            url_byte,
	output logic            host_byte
);
	import hrhc_pkg::*;

	byte_class_t cls;
	logic        cls_empty;
	logic        cls_pop;
	logic        res_full;
	logic        res_wr;
	result_t     res_in;
	result_t     res_out;

	hrhc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.byte_req (byte_req),
		.cls_pop  (cls_pop),
		.cls_empty(cls_empty),
		.cls      (cls)
	);

	hrhc_back #(
		.MAX_LINE(MAX_LINE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cls_empty(cls_empty),
		.cls      (cls),
		.cls_pop  (cls_pop),
		.res_full (res_full),
		.res_wr   (res_wr),
		.res      (res_in)
	);

	hrhc_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_wr),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign verdict   = res_out.verdict;
	assign url_byte  = res_out.url_byte;
	assign host_byte = res_out.host_byte;
endmodule
`default_nettype wire

>>> rtl/hrhc_fifo.sv
// Small flip-flop queue with occupancy count.
`default_nettype none
module hrhc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/hrhc_front.sv
// Front end: accepts request bytes, classifies them and queues the classes.
`default_nettype none
module hrhc_front #(
	parameter int DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            byte_req,
	input  wire logic                  cls_pop,
	output logic                       cls_empty,
	output hrhc_pkg::byte_class_t      cls
);
	import hrhc_pkg::*;

	logic [7:0]  lc;
	byte_class_t cls_in;

	assign lc = (byte_req >= 8'h41 && byte_req <= 8'h5a) ? byte_req + 8'h20 : byte_req;

	always_comb begin
		cls_in.is_blank = (byte_req == CH_SPACE) || (byte_req == CH_TAB);
		cls_in.is_cr    = (byte_req == CH_CR);
		cls_in.is_lf    = (byte_req == CH_LF);
		cls_in.is_slash = (byte_req == CH_SLASH);
		for (int i = 0; i < LEN_GET; i++) begin
			cls_in.get_hit[i] = (lc == LIT_GET[i]);
		end
		for (int i = 0; i < LEN_VER; i++) begin
			cls_in.ver_hit[i] = (lc == LIT_VER[i]);
		end
		for (int i = 0; i < LEN_PROTO; i++) begin
			cls_in.proto_hit[i] = (lc == LIT_PROTO[i]);
		end
		for (int i = 0; i < LEN_HOST; i++) begin
			cls_in.host_hit[i] = (lc == LIT_HOST[i]);
		end
	end

	hrhc_fifo #(
		.WIDTH($bits(byte_class_t)),
		.DEPTH(DEPTH)
	) u_cls_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cls_in),
		.full   (full),
		.rd_en  (cls_pop),
		.rd_data(cls),
		.empty  (cls_empty)
	);
endmodule
`default_nettype wire

>>> rtl/hrhc_back.sv
// Back end: request grammar state machine, one byte per cycle unless stalled.
`default_nettype none
module hrhc_back #(
	parameter int MAX_LINE = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cls_empty,
	input  wire hrhc_pkg::byte_class_t cls,
	output logic                       cls_pop,
	input  wire logic                  res_full,
	output logic                       res_wr,
	output hrhc_pkg::result_t          res
);
	import hrhc_pkg::*;

	localparam int LW = $clog2(MAX_LINE + 1);

	phase_t      phase_q, phase_d;
	url_form_t   form_q, form_d;
	logic [3:0]  mp_q, mp_d;
	logic        prev_cr_q, prev_cr_d;
	logic [LW-1:0] len_q, len_d;
	logic        hle_q, hle_d;
	logic        fire;
	logic        live;
	logic        bad;
	logic        get_ok, ver_ok, proto_ok, host_ok;

	assign fire    = !cls_empty && !res_full;
	assign cls_pop = fire;
	assign res_wr  = fire;

	assign get_ok   = (mp_q < 4'd3) && cls.get_hit[mp_q[1:0]];
	assign ver_ok   = (mp_q < 4'd8) && cls.ver_hit[mp_q[2:0]];
	assign proto_ok = (mp_q < 4'd7) && cls.proto_hit[mp_q[2:0]];
	assign host_ok  = (mp_q < 4'd5) && cls.host_hit[mp_q[2:0]];

	// True for an ordinary in-grammar byte that reaches the per-phase logic.
	assign live = (phase_q < PH_DONE) && (len_q < LW'(MAX_LINE)) && !prev_cr_q
		&& !cls.is_cr && !cls.is_lf;

	always_comb begin
		phase_d   = phase_q;
		form_d    = form_q;
		mp_d      = mp_q;
		prev_cr_d = prev_cr_q;
		len_d     = len_q;
		hle_d     = hle_q;
		bad       = 1'b0;
		if (phase_q == PH_DONE) begin
		end else if (phase_q >= PH_BAD) begin
			phase_d = PH_BAD;
		end else if (len_q >= LW'(MAX_LINE)) begin
			bad = 1'b1;
		end else begin
			len_d = len_q + 1'b1;
			if (prev_cr_q) begin
				if (cls.is_lf) begin
					len_d     = '0;
					prev_cr_d = 1'b0;
					if (phase_q == PH_VER && mp_q == 4'd8) begin
						phase_d = PH_HMATCH;
						mp_d    = '0;
						hle_d   = 1'b1;
					end else if (phase_q >= PH_HMATCH && phase_q <= PH_HOTHER) begin
						if (hle_q) begin
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_HMATCH;
							mp_d    = '0;
							hle_d   = 1'b1;
						end
					end else begin
						phase_d = PH_BAD;
					end
				end else begin
					bad = 1'b1;
				end
			end else if (cls.is_cr) begin
				prev_cr_d = 1'b1;
			end else if (cls.is_lf) begin
				bad = 1'b1;
			end else begin
				case (phase_q)
					PH_METHOD: begin
						if (cls.is_blank) begin
							if (mp_q == 4'd3) begin
								phase_d = PH_GAP1;
							end else begin
								bad = 1'b1;
							end
						end else if (get_ok) begin
							mp_d = mp_q + 1'b1;
						end else begin
							bad = 1'b1;
						end
					end
					PH_GAP1: begin
						if (!cls.is_blank) begin
							phase_d = PH_URL;
							if (cls.is_slash) begin
								form_d = UF_PATH;
							end else if (cls.proto_hit[0]) begin
								form_d = UF_PROTO;
								mp_d   = 4'd1;
							end else begin
								bad = 1'b1;
							end
						end
					end
					PH_URL: begin
						if (cls.is_blank) begin
							if (form_q == UF_PATH) begin
								phase_d = PH_GAP2;
								mp_d    = '0;
							end else begin
								bad = 1'b1;
							end
						end else if (form_q == UF_PATH) begin
						end else if (form_q == UF_HOST) begin
							if (cls.is_slash) begin
								form_d = UF_PATH;
							end
						end else if (proto_ok) begin
							mp_d = mp_q + 1'b1;
							if (mp_q == 4'd6) begin
								form_d = UF_HOST;
							end
						end else begin
							bad = 1'b1;
						end
					end
					PH_GAP2: begin
						if (!cls.is_blank) begin
							if (cls.ver_hit[0]) begin
								phase_d = PH_VER;
								mp_d    = 4'd1;
							end else begin
								bad = 1'b1;
							end
						end
					end
					PH_VER: begin
						if (ver_ok) begin
							mp_d = mp_q + 1'b1;
						end else begin
							bad = 1'b1;
						end
					end
					PH_HMATCH: begin
						hle_d = 1'b0;
						if (host_ok) begin
							mp_d = mp_q + 1'b1;
							if (mp_q == 4'd4) begin
								phase_d = PH_HSKIP;
							end
						end else begin
							phase_d = PH_HOTHER;
						end
					end
					PH_HSKIP: begin
						hle_d = 1'b0;
						if (!cls.is_blank) begin
							phase_d = PH_HVALUE;
						end
					end
					PH_HVALUE: begin
						hle_d = 1'b0;
					end
					PH_HOTHER: begin
						hle_d = 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
		if (bad) begin
			phase_d = PH_BAD;
		end
	end

	always_comb begin
		logic ub;
		logic hb;
		ub = live && (((phase_q == PH_GAP1) && cls.is_slash)
			|| ((phase_q == PH_URL) && !cls.is_blank
				&& ((form_q == UF_PATH) || ((form_q == UF_HOST) && cls.is_slash))));
		hb = live && (((phase_q == PH_HSKIP) && !cls.is_blank) || (phase_q == PH_HVALUE));
		case (phase_d)
			PH_DONE: res.verdict = VERDICT_GET;
			PH_BAD:  res.verdict = VERDICT_BAD;
			default: res.verdict = VERDICT_PENDING;
		endcase
		res.url_byte  = ub && (res.verdict == VERDICT_PENDING);
		res.host_byte = hb && (res.verdict == VERDICT_PENDING);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_METHOD;
			form_q    <= UF_NONE;
			mp_q      <= '0;
			prev_cr_q <= 1'b0;
			len_q     <= '0;
			hle_q     <= 1'b1;
		end else if (fire) begin
			phase_q   <= phase_d;
			form_q    <= form_d;
			mp_q      <= mp_d;
			prev_cr_q <= prev_cr_d;
			len_q     <= len_d;
			hle_q     <= hle_d;
		end
	end
endmodule
`default_nettype wire
